// File: rtl/dmc_pkg.sv
// Shared types, register codes and the rate table of the delta modulation channel.
`default_nettype none
package dmc_pkg;

  localparam int unsigned PERIOD_SCALE = 1;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [4:0] REG_CTRL   = 5'h10;
  localparam logic [4:0] REG_LEVEL  = 5'h11;
  localparam logic [4:0] REG_START  = 5'h12;
  localparam logic [4:0] REG_LENGTH = 5'h13;
  localparam logic [4:0] REG_STATUS = 5'h15;

  localparam logic [15:0] ADDR_BASE  = 16'hC000;
  localparam logic [15:0] ADDR_WRAP  = 16'h8000;
  localparam logic [6:0]  LEVEL_HIGH = 7'd125;

  typedef struct packed {
    logic [1:0] command;
    logic [4:0] reg_addr;
    logic [7:0] write_data;
    logic [7:0] mem_byte;
  } dmc_item_t;

  typedef struct packed {
    logic        irq;
    logic        fetched;
    logic [15:0] fetch_address;
    logic [6:0]  output_level;
    logic [7:0]  read_data;
  } dmc_res_t;

  // Timer reload per rate index, scaled and kept to 16 bits.
  function automatic logic [15:0] rate_lookup(input logic [3:0] idx);
    logic [15:0] base;
    logic [31:0] prod;
    unique case (idx)
      4'd0:    base = 16'd428;
      4'd1:    base = 16'd380;
      4'd2:    base = 16'd340;
      4'd3:    base = 16'd320;
      4'd4:    base = 16'd286;
      4'd5:    base = 16'd254;
      4'd6:    base = 16'd226;
      4'd7:    base = 16'd214;
      4'd8:    base = 16'd190;
      4'd9:    base = 16'd160;
      4'd10:   base = 16'd142;
      4'd11:   base = 16'd128;
      4'd12:   base = 16'd106;
      4'd13:   base = 16'd85;
      4'd14:   base = 16'd72;
      default: base = 16'd54;
    endcase
    prod = 32'(base) * 32'(PERIOD_SCALE);
    return prod[15:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/dmc_in_stage.sv
// Input register of the delta modulation channel.
`default_nettype none
module dmc_in_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire dmc_pkg::dmc_item_t in_item,
  input  wire logic              advance,
  output logic                   item_vld,
  output dmc_pkg::dmc_item_t     item
);
  import dmc_pkg::*;

  logic      vld_r;
  dmc_item_t item_r;

  // Take a new item whenever the held one is empty or moving on.
  assign in_ready = !vld_r || advance;
  assign item_vld = vld_r;
  assign item     = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule
`default_nettype wire

// File: rtl/dmc_core.sv
// Channel state and the per-item update: register writes, status read, tick.
`default_nettype none
module dmc_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               advance,
  input  wire dmc_pkg::dmc_item_t item,
  output dmc_pkg::dmc_res_t       res
);
  import dmc_pkg::*;

  logic [4:0]  enables_r,  enables_nxt;
  logic        irq_en_r,   irq_en_nxt;
  logic        loop_r,     loop_nxt;
  logic [15:0] period_r,   period_nxt;
  logic [15:0] timer_r,    timer_nxt;
  logic [6:0]  level_r,    level_nxt;
  logic [15:0] start_r,    start_nxt;
  logic [11:0] length_r,   length_nxt;
  logic [15:0] addr_r,     addr_nxt;
  logic [11:0] bytes_r,    bytes_nxt;
  logic [7:0]  buffer_r,   buffer_nxt;
  logic        empty_r,    empty_nxt;
  logic [7:0]  shifter_r,  shifter_nxt;
  logic [3:0]  bits_r,     bits_nxt;
  logic        silent_r,   silent_nxt;
  logic        irq_r,      irq_nxt;
  logic [7:0]  rd;
  logic        got;

  always_comb begin
    enables_nxt = enables_r;
    irq_en_nxt  = irq_en_r;
    loop_nxt    = loop_r;
    period_nxt  = period_r;
    timer_nxt   = timer_r;
    level_nxt   = level_r;
    start_nxt   = start_r;
    length_nxt  = length_r;
    addr_nxt    = addr_r;
    bytes_nxt   = bytes_r;
    buffer_nxt  = buffer_r;
    empty_nxt   = empty_r;
    shifter_nxt = shifter_r;
    bits_nxt    = bits_r;
    silent_nxt  = silent_r;
    irq_nxt     = irq_r;
    rd          = 8'd0;
    got         = 1'b0;

    case (item.command)
      CMD_WRITE: begin
        unique case (item.reg_addr)
          REG_CTRL: begin
            irq_en_nxt = item.write_data[7];
            loop_nxt   = item.write_data[6];
            period_nxt = rate_lookup(item.write_data[3:0]);
            timer_nxt  = period_nxt;
          end
          REG_LEVEL: level_nxt = item.write_data[6:0];
          REG_START: start_nxt = ADDR_BASE + {2'b00, item.write_data, 6'd0};
          REG_LENGTH: length_nxt = {item.write_data, 4'd0} + 12'd1;
          REG_STATUS: begin
            enables_nxt = item.write_data[4:0];
            if (!item.write_data[4]) begin
              // Disable: silence and drop the sample in progress.
              level_nxt   = 7'd0;
              bytes_nxt   = 12'd0;
              bits_nxt    = 4'd0;
              shifter_nxt = 8'd0;
              empty_nxt   = 1'b1;
              silent_nxt  = 1'b1;
              irq_nxt     = 1'b0;
            end else if (bytes_r == 12'd0) begin
              // Enable with nothing left: restart the sample.
              addr_nxt   = start_r;
              bytes_nxt  = length_r;
              bits_nxt   = 4'd0;
              empty_nxt  = 1'b1;
              silent_nxt = 1'b1;
              irq_nxt    = 1'b0;
            end
          end
          default: ;
        endcase
      end
      CMD_READ: begin
        if (item.reg_addr == REG_STATUS) begin
          rd      = {irq_r, 2'b00, enables_r};
          irq_nxt = 1'b0;
        end
      end
      CMD_TICK: begin
        if (enables_r[4]) begin
          if (timer_r > 16'd1) begin
            timer_nxt = timer_r - 16'd1;
          end else begin
            timer_nxt = timer_r + period_r - 16'd1;
            // Fetch the byte offered with this tick.
            if (empty_r && bytes_r != 12'd0) begin
              buffer_nxt = item.mem_byte;
              empty_nxt  = 1'b0;
              got        = 1'b1;
              addr_nxt   = (addr_r == 16'hFFFF) ? ADDR_WRAP : addr_r + 16'd1;
              bytes_nxt  = bytes_r - 12'd1;
              if (bytes_nxt == 12'd0) begin
                if (loop_r) begin
                  addr_nxt  = start_r;
                  bytes_nxt = length_r;
                end else if (irq_en_r) begin
                  irq_nxt = 1'b1;
                end
              end
            end
            // Reload the shifter at the end of an output cycle.
            if (bits_r == 4'd0) begin
              if (empty_nxt) begin
                silent_nxt = 1'b1;
              end else begin
                silent_nxt  = 1'b0;
                shifter_nxt = buffer_nxt;
                empty_nxt   = 1'b1;
              end
              bits_nxt = 4'd8;
            end
            if (!silent_nxt) begin
              if (shifter_nxt[0]) begin
                if (level_r <= LEVEL_HIGH) level_nxt = level_r + 7'd2;
              end else begin
                if (level_r >= 7'd2) level_nxt = level_r - 7'd2;
              end
            end
            shifter_nxt = {1'b0, shifter_nxt[7:1]};
            bits_nxt    = bits_nxt - 4'd1;
          end
        end
      end
      default: ;
    endcase
  end

  assign res.read_data     = rd;
  assign res.output_level  = level_nxt;
  assign res.fetch_address = addr_nxt;
  assign res.fetched       = got;
  assign res.irq           = irq_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enables_r <= 5'd0;
      irq_en_r  <= 1'b0;
      loop_r    <= 1'b0;
      period_r  <= rate_lookup(4'd0);
      timer_r   <= rate_lookup(4'd0);
      level_r   <= 7'd0;
      start_r   <= ADDR_BASE;
      length_r  <= 12'd1;
      addr_r    <= ADDR_BASE;
      bytes_r   <= 12'd0;
      buffer_r  <= 8'd0;
      empty_r   <= 1'b1;
      shifter_r <= 8'd0;
      bits_r    <= 4'd0;
      silent_r  <= 1'b1;
      irq_r     <= 1'b0;
    end else if (advance) begin
      enables_r <= enables_nxt;
      irq_en_r  <= irq_en_nxt;
      loop_r    <= loop_nxt;
      period_r  <= period_nxt;
      timer_r   <= timer_nxt;
      level_r   <= level_nxt;
      start_r   <= start_nxt;
      length_r  <= length_nxt;
      addr_r    <= addr_nxt;
      bytes_r   <= bytes_nxt;
      buffer_r  <= buffer_nxt;
      empty_r   <= empty_nxt;
      shifter_r <= shifter_nxt;
      bits_r    <= bits_nxt;
      silent_r  <= silent_nxt;
      irq_r     <= irq_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/dmc_out_stage.sv
// Result register of the delta modulation channel.
`default_nettype none
module dmc_out_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire dmc_pkg::dmc_res_t res,
  output logic                   slot_free,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output dmc_pkg::dmc_res_t      out_res
);
  import dmc_pkg::*;

  logic     vld_r;
  dmc_res_t res_r;

  assign slot_free = !vld_r || out_ready;
  assign out_valid = vld_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (slot_free) begin
      vld_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule
`default_nettype wire

// File: rtl/delta_modulation_sample_channel_top.sv
// Top level of the delta modulation sample channel with stream ports.
`default_nettype none
// Each input item is a register write, a status read or one clock tick of the
// channel, selected by in_tuser; every item yields exactly one result item
// carrying the status byte (nonzero only for a read of the status register),
// the 7-bit output level, the next fetch address, the fetched flag and the
// IRQ flag. An item enters an input register, its whole effect on the channel
// state is computed combinationally from that register, and the result lands
// in an output register: the block sustains one item per clock while
// out_tready is high, and a result is valid on the output once it is held in
// the output register. Throughput is set by the state update, which every
// item must finish before the next one reads the state. The output register
// lets a new item enter while a result waits; when out_tready stays low the
// input register fills and in_tready drops. On a tick that fetches, in_tdata
// must carry the memory byte at the fetch address reported in the previous
// result.
module delta_modulation_sample_channel_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [1:0]  in_tuser,   // command
  input  wire logic [23:0] in_tdata,   // reg_addr[4:0], write_data[12:5], mem_byte[20:13]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // read_data[7:0], output_level[14:8], fetch_address[30:15], fetched[31], irq[32]
  output logic [39:0]      out_tdata
);
  import dmc_pkg::*;

  dmc_item_t in_item;
  dmc_item_t item;
  dmc_res_t  res;
  dmc_res_t  out_res;
  logic      item_vld;
  logic      slot_free;
  logic      advance;

  assign in_item.command    = in_tuser;
  assign in_item.reg_addr   = in_tdata[4:0];
  assign in_item.write_data = in_tdata[12:5];
  assign in_item.mem_byte   = in_tdata[20:13];

  // Move the held item on when the result register can take its result.
  assign advance = item_vld && slot_free;

  dmc_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .advance  (advance),
    .item_vld (item_vld),
    .item     (item)
  );

  dmc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item),
    .res     (res)
  );

  dmc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .res       (res),
    .slot_free (slot_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {7'd0, out_res};

endmodule
`default_nettype wire
